### hw/rtl/bed_pkg.sv
// Shared types, codes and character helpers for the backslash escape decoder.
`default_nettype none

package bed_pkg;

	// Decoder modes, one-hot.
	typedef enum logic [6:0] {
		MODE_PLAIN = 7'b0000001,
		MODE_ESC   = 7'b0000010,
		MODE_OCT1  = 7'b0000100,
		MODE_OCT2  = 7'b0001000,
		MODE_HEX1  = 7'b0010000,
		MODE_HEX2  = 7'b0100000,
		MODE_DROP  = 7'b1000000
	} mode_t;

	// Error codes carried on the result.
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_TRAIL   = 3'd1;
	localparam logic [2:0] ERR_OCTPART = 3'd2;
	localparam logic [2:0] ERR_OCTBIG  = 3'd3;
	localparam logic [2:0] ERR_HEXPART = 3'd4;
	localparam logic [2:0] ERR_UNKNOWN = 3'd5;

	localparam int unsigned ACC_W = 10;

	// Characters that the decoder looks for.
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_H      = 8'h68;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	// One decoded result.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic [2:0] err;
		logic       last;
	} result_t;

	// Hex digit value in the low four bits; bit 4 set when not a hex digit.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c inside {[8'h30:8'h39]}) begin
			v = {1'b0, c[3:0]};
		end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			v = {1'b0, c[3:0] + 4'd9};
		end
		return v;
	endfunction

	// Mapped byte of a single-letter escape; bit 8 set when there is none.
	function automatic logic [8:0] letter_map(input logic [7:0] c);
		logic [8:0] v;
		case (c)
			8'h61: v = 9'd7;
			8'h62: v = 9'd8;
			8'h66: v = 9'd12;
			8'h6E: v = 9'd10;
			8'h72: v = 9'd13;
			8'h74: v = 9'd9;
			8'h76: v = 9'd11;
			8'h5C: v = 9'h05C;
			8'h27: v = 9'h027;
			8'h22: v = 9'h022;
			default: v = 9'h100;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/bed_in_if.sv
// Input channel: one raw character per transaction.
`default_nettype none

interface bed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/bed_out_if.sv
// Output channel: one decoded character or error per transaction.
`default_nettype none

interface bed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [2:0] error_code;
	logic       out_last;

	modport source (output valid, output out_byte, output error_code, output out_last,
		input ready);
	modport sink (input valid, input out_byte, input error_code, input out_last,
		output ready);
endinterface

`default_nettype wire

### hw/rtl/bed_decode.sv
// Next-mode and result logic for one input character.
`default_nettype none

module bed_decode (
	input  bed_pkg::mode_t              mode,
	input  logic [bed_pkg::ACC_W-1:0]   acc,
	input  logic [7:0]                  in_byte,
	input  logic                        in_last,
	output bed_pkg::mode_t              mode_nxt,
	output logic [bed_pkg::ACC_W-1:0]   acc_nxt,
	output bed_pkg::result_t            res
);
	import bed_pkg::*;

	logic [3:0]       dig;
	logic [4:0]       hv;
	logic [8:0]       lm;
	logic [ACC_W-1:0] oct_sum;
	logic             is_dec;
	logic             is_oct;

	// For a decimal digit character the low nibble is its value.
	assign dig     = in_byte[3:0];
	assign is_dec  = in_byte inside {[8'h30:8'h39]};
	assign is_oct  = in_byte inside {[8'h30:8'h37]};
	assign hv      = hex_val(in_byte);
	assign lm      = letter_map(in_byte);
	assign oct_sum = acc + {{(ACC_W-3){1'b0}}, dig[2:0]};

	always_comb begin
		logic [2:0] ferr;
		logic       fail;
		fail     = 1'b0;
		ferr     = ERR_NONE;
		mode_nxt = mode;
		acc_nxt  = acc;
		res      = '0;

		case (mode)
			MODE_ESC: begin
				if (is_dec) begin
					if (in_last) begin
						fail = 1'b1;
						ferr = ERR_OCTPART;
					end else begin
						acc_nxt  = {dig, 6'b0};
						mode_nxt = MODE_OCT1;
					end
				end else if (in_byte == CH_H) begin
					if (in_last) begin
						fail = 1'b1;
						ferr = ERR_HEXPART;
					end else begin
						acc_nxt  = '0;
						mode_nxt = MODE_HEX1;
					end
				end else if (lm[8]) begin
					fail = 1'b1;
					ferr = ERR_UNKNOWN;
				end else begin
					mode_nxt  = MODE_PLAIN;
					res.valid = 1'b1;
					res.data  = lm[7:0];
					res.last  = in_last;
				end
			end
			MODE_OCT1: begin
				if (!is_oct || in_last) begin
					fail = 1'b1;
					ferr = ERR_OCTPART;
				end else begin
					acc_nxt  = acc + {{(ACC_W-6){1'b0}}, dig[2:0], 3'b0};
					mode_nxt = MODE_OCT2;
				end
			end
			MODE_OCT2: begin
				if (!is_oct) begin
					fail = 1'b1;
					ferr = ERR_OCTPART;
				end else if (oct_sum > ACC_W'(255)) begin
					fail = 1'b1;
					ferr = ERR_OCTBIG;
				end else begin
					mode_nxt  = MODE_PLAIN;
					acc_nxt   = '0;
					res.valid = 1'b1;
					res.data  = oct_sum[7:0];
					res.last  = in_last;
				end
			end
			MODE_HEX1: begin
				if (hv[4] || in_last) begin
					fail = 1'b1;
					ferr = ERR_HEXPART;
				end else begin
					acc_nxt  = {{(ACC_W-4){1'b0}}, hv[3:0]};
					mode_nxt = MODE_HEX2;
				end
			end
			MODE_HEX2: begin
				if (hv[4]) begin
					fail = 1'b1;
					ferr = ERR_HEXPART;
				end else begin
					mode_nxt  = MODE_PLAIN;
					acc_nxt   = '0;
					res.valid = 1'b1;
					res.data  = {acc[3:0], hv[3:0]};
					res.last  = in_last;
				end
			end
			MODE_DROP: begin
				if (in_last) begin
					mode_nxt = MODE_PLAIN;
				end
			end
			default: begin
				// Plain mode, and any code that names no mode.
				mode_nxt = MODE_PLAIN;
				if (in_byte == CH_BSLASH) begin
					if (in_last) begin
						fail = 1'b1;
						ferr = ERR_TRAIL;
					end else begin
						mode_nxt = MODE_ESC;
					end
				end else begin
					res.valid = 1'b1;
					res.data  = in_byte;
					res.last  = in_last;
				end
			end
		endcase

		// A malformed escape ends the string with an error result.
		if (fail) begin
			mode_nxt  = in_last ? MODE_PLAIN : MODE_DROP;
			acc_nxt   = '0;
			res.valid = 1'b1;
			res.data  = '0;
			res.err   = ferr;
			res.last  = 1'b1;
		end
	end
endmodule

`default_nettype wire

### hw/rtl/backslash_escape_decoder.sv
// Top level of the backslash escape decoder: mode register and output buffering.
// Results are registered; the mode and accumulator update is the only loop.
// Throughput: one character per cycle while the skid entry is empty.
// A two-entry output buffer keeps input flowing under output stall until it fills.
// Reset clears the mode to plain, the accumulator to zero and both output valids.
`default_nettype none

module backslash_escape_decoder (
	input  logic         clk,
	input  logic         arst_n,
	bed_in_if.sink       in_stream,
	bed_out_if.source    out_stream
);
	import bed_pkg::*;

	mode_t            mode_q;
	mode_t            mode_nxt;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] acc_nxt;
	result_t          res;
	result_t          out_q;
	result_t          skid_q;
	logic             accept;
	logic             push;
	logic             pop;

	bed_decode u_decode (
		.mode     (mode_q),
		.acc      (acc_q),
		.in_byte  (in_stream.in_byte),
		.in_last  (in_stream.in_last),
		.mode_nxt (mode_nxt),
		.acc_nxt  (acc_nxt),
		.res      (res)
	);

	assign in_stream.ready = !skid_q.valid;
	assign accept          = in_stream.valid && in_stream.ready;
	assign push            = accept && res.valid;
	assign pop             = out_q.valid && out_stream.ready;

	// Decoder state advances on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			acc_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_nxt;
			acc_q  <= acc_nxt;
		end
	end

	// Output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q  <= '0;
			skid_q <= '0;
		end else if (skid_q.valid) begin
			if (pop) begin
				out_q        <= skid_q;
				skid_q.valid <= 1'b0;
			end
		end else if (push) begin
			if (!out_q.valid || pop) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (pop) begin
			out_q.valid <= 1'b0;
		end
	end

	assign out_stream.valid      = out_q.valid;
	assign out_stream.out_byte   = out_q.data;
	assign out_stream.error_code = out_q.err;
	assign out_stream.out_last   = out_q.last;
endmodule

`default_nettype wire
